// ===== hdl/xor_masked_base64_name_codec_top_defines.svh =====
// Assertion macros for the name codec RTL.
// Included by the modules that carry assertions; needs clk and rst in scope.
`ifndef XOR_MASKED_BASE64_NAME_CODEC_TOP_DEFINES_SVH
`define XOR_MASKED_BASE64_NAME_CODEC_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define XMB_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define XMB_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define XMB_CHECK(lbl, expr, msg)
`define XMB_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/xmb64_pkg.sv =====
// Shared types, constants and table functions for the name codec.
// No dependencies; used by xmb64_core and the top level.
package xmb64_pkg;

  localparam int NAME_BYTES  = 12;
  localparam int KEY_LEN     = 10;
  localparam int GROUP_COUNT = (NAME_BYTES + 2) / 3;
  localparam int NAME_CHARS  = 4 * GROUP_COUNT;
  localparam int POS_W       = $clog2(NAME_CHARS);
  localparam int BASE_W      = $clog2(NAME_BYTES);
  localparam int KEY_W       = $clog2(KEY_LEN);
  localparam int RUN_CNT_W   = 3;

  // Key bytes, first byte in the top entry.
  localparam logic [KEY_LEN-1:0][7:0] KEY_BYTES = 80'h54616f62616f2d696e63;

  // Permuted alphabet, sextet 0 in the top entry.
  localparam logic [63:0][7:0] ALPHABET = {
    "0JoU8EaN3xf19hIS2d.6pZRFBYurMDGw",
    "7K5m4CyXsbQjg_vTOAkcHVtzqWilnLPe"
  };

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       name_done;
  } out_item_t;

  // A run of result beats caused by one item; bytes[0] goes out first.
  typedef struct packed {
    logic [RUN_CNT_W-1:0] cnt;
    logic [3:0][7:0]      bytes;
    logic                 done;
  } run_t;

  // Inverse alphabet, built at elaboration; unknown characters map to 0.
  function automatic logic [255:0][5:0] build_inv();
    logic [255:0][5:0] inv;
    inv = '0;
    for (int i = 0; i < 64; i++) begin
      inv[ALPHABET[63-i]] = 6'(i);
    end
    return inv;
  endfunction

  localparam logic [255:0][5:0] INV_TABLE = build_inv();

  function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] k);
    return KEY_BYTES[KEY_W'(KEY_LEN - 1) - k];
  endfunction

  function automatic logic [7:0] alpha_char(input logic [5:0] s);
    return ALPHABET[~s];
  endfunction

  // Key index plus a small step, wrapped at the key length.
  function automatic logic [KEY_W-1:0] key_add(input logic [KEY_W-1:0] k,
                                               input logic [1:0] inc);
    logic [KEY_W:0] s;
    s = {1'b0, k} + {{(KEY_W-1){1'b0}}, inc};
    if (s >= (KEY_W+1)'(KEY_LEN)) begin
      s = s - (KEY_W+1)'(KEY_LEN);
    end
    return s[KEY_W-1:0];
  endfunction

endpackage

// ===== hdl/xmb64_core.sv =====
// Codec datapath: position/key counters, group accumulator, run builder.
// Depends on xmb64_pkg and the assertion macro header.
`include "xor_masked_base64_name_codec_top_defines.svh"

module xmb64_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  xmb64_pkg::in_item_t item,
  input  logic               advance,
  output xmb64_pkg::run_t    run
);
  import xmb64_pkg::*;

  logic              mode;
  logic [POS_W-1:0]  pos, pos_next;
  logic [23:0]       acc, acc_next;
  logic [KEY_W-1:0]  kidx, kidx_next;
  logic [1:0]        ph, ph_next;
  logic [BASE_W-1:0] base, base_next;

  logic [POS_W-1:0]  p;
  logic [23:0]       a;
  logic [KEY_W-1:0]  k;
  logic [1:0]        ph_e;
  logic [BASE_W-1:0] b;
  logic [BASE_W:0]   b_ext;

  logic [23:0]       acc_e, acc_d, g;
  logic              emit_e, emit_d, last_e, last_d;
  logic [RUN_CNT_W-1:0] cnt_d;

  // A start request clears the position, group and key state before the item is used.
  assign p    = item.start_req ? '0 : pos;
  assign a    = item.start_req ? '0 : acc;
  assign k    = item.start_req ? '0 : kidx;
  assign ph_e = item.start_req ? '0 : ph;
  assign b    = item.start_req ? '0 : base;
  assign b_ext = {1'b0, b};

  assign acc_e  = {a[15:0], item.in_byte ^ key_byte(k)};
  assign last_e = (p == POS_W'(NAME_BYTES - 1));
  assign emit_e = (ph_e == 2'd2) || last_e;

  assign acc_d  = {a[17:0], INV_TABLE[item.in_byte]};
  assign last_d = (p == POS_W'(NAME_CHARS - 1));
  assign emit_d = (p[1:0] == 2'd3);

  always_comb begin
    case (ph_e)
      2'd0:    g = {acc_e[7:0], 16'h0000};
      2'd1:    g = {acc_e[15:0], 8'h00};
      default: g = acc_e;
    endcase
  end

  // Drop bytes of the last group that fall past the record length.
  always_comb begin
    if (b_ext + (BASE_W+1)'(2) < (BASE_W+1)'(NAME_BYTES)) begin
      cnt_d = RUN_CNT_W'(3);
    end else if (b_ext + (BASE_W+1)'(1) < (BASE_W+1)'(NAME_BYTES)) begin
      cnt_d = RUN_CNT_W'(2);
    end else begin
      cnt_d = RUN_CNT_W'(1);
    end
  end

  always_comb begin
    run = '0;
    if (mode) begin
      run.cnt      = emit_d ? cnt_d : '0;
      run.bytes[0] = acc_d[23:16] ^ key_byte(k);
      run.bytes[1] = acc_d[15:8]  ^ key_byte(key_add(k, 2'd1));
      run.bytes[2] = acc_d[7:0]   ^ key_byte(key_add(k, 2'd2));
      run.bytes[3] = 8'h00;
      run.done     = last_d;
    end else begin
      run.cnt      = emit_e ? RUN_CNT_W'(4) : '0;
      run.bytes[0] = alpha_char(g[23:18]);
      run.bytes[1] = alpha_char(g[17:12]);
      run.bytes[2] = alpha_char(g[11:6]);
      run.bytes[3] = alpha_char(g[5:0]);
      run.done     = last_e;
    end
  end

  always_comb begin
    pos_next  = POS_W'(p + POS_W'(1));
    acc_next  = '0;
    kidx_next = k;
    ph_next   = '0;
    base_next = b;
    if (mode) begin
      if (last_d) begin
        pos_next  = '0;
        kidx_next = '0;
        base_next = '0;
      end else if (emit_d) begin
        base_next = BASE_W'(b_ext + (BASE_W+1)'(3));
        kidx_next = key_add(k, 2'd3);
      end else begin
        acc_next = acc_d;
      end
    end else begin
      if (last_e) begin
        pos_next  = '0;
        kidx_next = '0;
      end else begin
        acc_next  = emit_e ? 24'h000000 : acc_e;
        kidx_next = key_add(k, 2'd1);
        ph_next   = (ph_e == 2'd2) ? 2'd0 : ph_e + 2'd1;
      end
      base_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      pos  <= '0;
      acc  <= '0;
      kidx <= '0;
      ph   <= '0;
      base <= '0;
    end else if (cfg_we) begin
      // mode write restarts the name
      mode <= cfg_wdata;
      pos  <= '0;
      acc  <= '0;
      kidx <= '0;
      ph   <= '0;
      base <= '0;
    end else if (advance) begin
      pos  <= pos_next;
      acc  <= acc_next;
      kidx <= kidx_next;
      ph   <= ph_next;
      base <= base_next;
    end
  end

  `XMB_CHECK(a_pos_range, {1'b0, pos} < (POS_W+1)'(NAME_CHARS), "position past name length")
  `XMB_CHECK(a_enc_pos, mode || ({1'b0, pos} < (POS_W+1)'(NAME_BYTES)), "encode position too big")
  `XMB_CHECK(a_key_range, {1'b0, kidx} < (KEY_W+1)'(KEY_LEN), "key index out of range")
  `XMB_CHECK(a_grp_clear, !mode || (pos[1:0] != 2'd0) || (acc == 24'h000000), "stale group")

endmodule

// ===== hdl/xor_masked_base64_name_codec_top.sv =====
// Top level of the masked base64 name codec: input register, run buffer, port glue.
// Depends on xmb64_pkg, xmb64_core and the assertion macro header.
//
// Usage: input beats (in_data) enter on in_valid/in_stall, one byte of a
// name record (encode) or one name character (decode) per beat; result beats
// leave on out_valid/out_stall, one byte each. cfg_we/cfg_wdata set the mode
// (0 encode, 1 decode) and restart the name; the user must write them only while
// the block is idle, which the block itself does not enforce. A beat with
// start_req high begins a new name. The input beat completing a group is
// captured in the input register, then loads the run buffer once it is free, which
// shows the first result beat. Throughput: one input beat per cycle while no group
// is pending. Each group loads a run of up to four beats into the run buffer, which
// drains one beat per cycle while out_stall is low; in encode four output beats per
// three inputs make the output port the limit, in decode one item per cycle.
// Reset clears the mode to encode, the position counters and both buffers.
// When the receiver stalls, the current result beat holds, the run buffer
// stops draining, and once a new run is waiting in the input register
// in_stall rises until the buffer frees.
`include "xor_masked_base64_name_codec_top_defines.svh"

module xor_masked_base64_name_codec_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  xmb64_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output xmb64_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);
  import xmb64_pkg::*;

  logic     in_vld;
  in_item_t in_q;
  run_t     run;
  run_t     run_q;
  logic [1:0] run_idx;
  logic     out_fire, run_free, adv;

  xmb64_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (in_q),
    .advance   (adv),
    .run       (run)
  );

  assign out_fire = (run_q.cnt != '0) && !out_stall;
  assign run_free = (run_q.cnt == '0) || ((run_q.cnt == RUN_CNT_W'(1)) && !out_stall);
  assign adv      = in_vld && ((run.cnt == '0) || run_free);
  assign in_stall = in_vld && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!in_stall) begin
      in_vld <= in_valid;
      in_q   <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_q.cnt <= '0;
      run_idx   <= '0;
    end else if (adv && (run.cnt != '0)) begin
      run_q   <= run;
      run_idx <= '0;
    end else if (out_fire) begin
      // advance to the next beat of the run
      run_q.cnt <= run_q.cnt - RUN_CNT_W'(1);
      run_idx   <= run_idx + 2'd1;
    end
  end

  assign out_valid          = (run_q.cnt != '0);
  assign out_data.out_byte  = run_q.bytes[run_idx];
  assign out_data.run_last  = (run_q.cnt == RUN_CNT_W'(1));
  assign out_data.name_done = run_q.done && (run_q.cnt == RUN_CNT_W'(1));

  `XMB_CHECK(a_run_cnt, run_q.cnt <= RUN_CNT_W'(4), "run count above four")
  `XMB_CHECK(a_load_free, !(adv && (run.cnt != '0)) || run_free, "run loaded over pending beats")
  `XMB_CHECK_NEXT(a_in_hold, in_vld && in_stall, in_vld, "held input beat lost")

endmodule

// ===== tb/sv/xor_masked_base64_name_codec_top_test.sv =====
// Self-checking testbench for the masked base64 name codec top level.
// Needs xmb64_pkg and xor_masked_base64_name_codec_top; predicts every result
// beat in a scoreboard class and drives both handshakes with random idling.
`timescale 1ns / 100ps

localparam int REC_BYTES = xmb64_pkg::NAME_BYTES;
localparam int REC_CHARS = xmb64_pkg::NAME_CHARS;
localparam logic [79:0] MASK_KEY = 80'h54_61_6f_62_61_6f_2d_69_6e_63;
localparam logic [511:0] CHAR_SET = {
  "0JoU8EaN3xf19hIS2d.6pZRFBYurMDGw",
  "7K5m4CyXsbQjg_vTOAkcHVtzqWilnLPe"
};

class name_codec_scoreboard;
  xmb64_pkg::out_item_t expected_beats[$];
  bit decode_on;
  logic [4:0] position;
  logic [23:0] group_bits;
  int errors;

  function void set_mode(bit m);
    decode_on = m;
    position = '0;
    group_bits = '0;
  endfunction

  function logic [7:0] key_at(int p);
    return MASK_KEY[79 - 8 * (p % 10) -: 8];
  endfunction

  function logic [7:0] char_at(int s);
    return CHAR_SET[511 - 8 * s -: 8];
  endfunction

  // Unknown characters fall back to sextet zero.
  function logic [5:0] sextet_for(logic [7:0] c);
    int i;
    for (i = 0; i < 64; i++) begin
      if (char_at(i) == c) begin
        return 6'(i);
      end
    end
    return 6'd0;
  endfunction

  function int outstanding();
    return expected_beats.size();
  endfunction

  function void note_input(xmb64_pkg::in_item_t it);
    int p;
    int k;
    int base;
    int cnt;
    logic [23:0] g;
    xmb64_pkg::out_item_t beat;
    if (it.start_req) begin
      position = '0;
      group_bits = '0;
    end
    p = position;
    if (!decode_on) begin
      if (p >= REC_BYTES) begin
        p = 0;
        group_bits = '0;
      end
      group_bits = {group_bits[15:0], it.in_byte ^ key_at(p)};
      if (p % 3 == 2 || p == REC_BYTES - 1) begin
        // pad missing low bytes of a short final group with zero
        g = group_bits << (8 * (2 - p % 3));
        for (k = 0; k < 4; k++) begin
          beat.out_byte = char_at(g[23 - 6 * k -: 6]);
          beat.run_last = (k == 3);
          beat.name_done = (k == 3) && (p == REC_BYTES - 1);
          expected_beats.push_back(beat);
        end
        group_bits = '0;
      end
      p++;
      position = (p >= REC_BYTES) ? 5'd0 : 5'(p);
    end else begin
      if (p >= REC_CHARS) begin
        p = 0;
        group_bits = '0;
      end
      group_bits = {group_bits[17:0], sextet_for(it.in_byte)};
      if (p % 4 == 3) begin
        base = (p / 4) * 3;
        cnt = 0;
        for (k = 0; k < 3; k++) begin
          if (base + k < REC_BYTES) cnt++;
        end
        // drop bytes past the record length
        for (k = 0; k < cnt; k++) begin
          beat.out_byte = group_bits[23 - 8 * k -: 8] ^ key_at(base + k);
          beat.run_last = (k + 1 == cnt);
          beat.name_done = (k + 1 == cnt) && (p == REC_CHARS - 1);
          expected_beats.push_back(beat);
        end
        group_bits = '0;
      end
      p++;
      position = (p >= REC_CHARS) ? 5'd0 : 5'(p);
    end
  endfunction

  function void check_result(xmb64_pkg::out_item_t got);
    xmb64_pkg::out_item_t want;
    if (expected_beats.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual %02h/%0b/%0b", $time,
               got.out_byte, got.run_last, got.name_done);
      errors++;
      return;
    end
    want = expected_beats.pop_front();
    if (got.out_byte !== want.out_byte) begin
      $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte,
               got.out_byte);
      errors++;
    end
    if (got.run_last !== want.run_last) begin
      $display("%0t: run_last expected %0b actual %0b", $time, want.run_last,
               got.run_last);
      errors++;
    end
    if (got.name_done !== want.name_done) begin
      $display("%0t: name_done expected %0b actual %0b", $time, want.name_done,
               got.name_done);
      errors++;
    end
  endfunction
endclass

module xor_masked_base64_name_codec_top_test;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [95:0] EDGE_BYTES = 96'h00_ff_00_ff_55_aa_01_80_7f_fe_00_ff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  xmb64_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  xmb64_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  name_codec_scoreboard sb;
  bit idle_on = 1'b1;
  bit hold_off_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int cycle_count = 0;

  xor_masked_base64_name_codec_top u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("xor_masked_base64_name_codec_top regression: fail");
      $finish;
    end
  end

  // Receiver: check accepted beats, then pick the next stall value.
  always @(posedge clk) begin
    logic next_stall;
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    next_stall = 1'b0;
    if (hold_off_req) begin
      hold_left = 90;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      next_stall = 1'b1;
    end else if (!idle_on) begin
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      next_stall = 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      next_stall = 1'b1;
    end
    out_stall <= next_stall;
  end

  task automatic send_item(input xmb64_pkg::in_item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  // Drop valid, wait for every expected beat, then let the pipeline settle.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_mode(m);
  endtask

  // Mostly whole names with random content; some cut short, some stray starts.
  task automatic random_names(input int budget);
    int sent;
    int len;
    int full;
    int i;
    xmb64_pkg::in_item_t it;
    full = sb.decode_on ? REC_CHARS : REC_BYTES;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, full - 1) : full;
      for (i = 0; i < len && sent < budget; i++) begin
        it.start_req = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 49) == 0);
        if (!sb.decode_on || $urandom_range(0, 9) == 0) begin
          it.in_byte = 8'($urandom_range(0, 255));
        end else begin
          it.in_byte = sb.char_at($urandom_range(0, 63));
        end
        send_item(it);
        sent++;
      end
    end
  endtask

  initial begin
    xmb64_pkg::in_item_t it;
    int i;
    sb = new();
    sb.set_mode(1'b0);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_mode(1'b0);

    // encode: one full name of edge bytes, then a restart inside a group
    for (i = 0; i < REC_BYTES; i++) begin
      it.start_req = (i == 0);
      it.in_byte = EDGE_BYTES[95 - 8 * i -: 8];
      send_item(it);
    end
    it = '{in_byte: 8'h3c, start_req: 1'b0};
    send_item(it);
    it = '{in_byte: 8'hc3, start_req: 1'b1};
    send_item(it);
    drain_block();

    // decode: partial group cut by a start, then unknown and edge characters
    write_mode(1'b1);
    it = '{in_byte: "J", start_req: 1'b0};
    send_item(it);
    it = '{in_byte: "o", start_req: 1'b0};
    send_item(it);
    it = '{in_byte: 8'h00, start_req: 1'b1};
    send_item(it);
    it = '{in_byte: 8'hff, start_req: 1'b0};
    send_item(it);
    it = '{in_byte: "0", start_req: 1'b0};
    send_item(it);
    it = '{in_byte: "e", start_req: 1'b0};
    send_item(it);
    it = '{in_byte: "+", start_req: 1'b0};
    send_item(it);
    it = '{in_byte: "/", start_req: 1'b0};
    send_item(it);
    it = '{in_byte: "_", start_req: 1'b0};
    send_item(it);
    it = '{in_byte: ".", start_req: 1'b0};
    send_item(it);
    drain_block();

    // hold the receiver off long enough for the input side to back up
    write_mode(1'b0);
    hold_off_req = 1'b1;
    random_names(40);
    drain_block();
    write_mode(1'b1);
    random_names(40);
    drain_block();
    // rewrite the same mode mid-name to restart the position
    write_mode(1'b1);
    random_names(15);
    drain_block();

    idle_on = 1'b0;
    write_mode(1'b0);
    random_names(15);
    drain_block();
    write_mode(1'b1);
    random_names(15);
    drain_block();

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("xor_masked_base64_name_codec_top regression: pass");
    end else begin
      $display("xor_masked_base64_name_codec_top regression: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/xmb64_pkg.sv
hdl/xmb64_core.sv
hdl/xor_masked_base64_name_codec_top.sv
tb/sv/xor_masked_base64_name_codec_top_test.sv
